@@ src/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");

`endif

@@ src/gttc_pkg.sv @@
// Package: constants, codes and port widths of the gate travel tick counter.
`timescale 1ns / 1ps
`default_nettype none
package gttc_pkg;

  localparam int CountWidthDef = 16;

  localparam int RegWidth = 8;
  localparam int CfgIdxWidth = 1;
  localparam logic [CfgIdxWidth-1:0] REG_SLOW_RELOAD = 1'b0;
  localparam logic [CfgIdxWidth-1:0] REG_DECEL_RELOAD = 1'b1;
  localparam logic [RegWidth-1:0] SlowReloadRst = 8'd50;
  localparam logic [RegWidth-1:0] DecelReloadRst = 8'd10;

  localparam int OutWidth = 16;
  localparam int InDataWidth = 24;
  localparam int InUserWidth = 3;
  localparam int OutDataWidth = 120;

  typedef enum logic [2:0] {
    ACT_TICK        = 3'd0,
    ACT_LOAD_POS    = 3'd1,
    ACT_LOAD_ONTIME = 3'd2,
    ACT_LOAD_MAIN   = 3'd3,
    ACT_CLEAR_LEARN = 3'd4
  } action_t;

  localparam logic [1:0] DIR_OPEN = 2'd1;
  localparam logic [1:0] DIR_CLOSE = 2'd2;

  localparam int LT_OPEN = 0;
  localparam int LT_CLOSE = 1;
  localparam int LT_DECEL_OPEN = 2;
  localparam int LT_DECEL_CLOSE = 3;
  localparam int NumLearn = 4;

endpackage
`default_nettype wire

@@ src/gate_travel_tick_counter.sv @@
// Top level: gate travel tick counter with input register and result register.
`timescale 1ns / 1ps
`default_nettype none
// Gate travel tick counter. Every item produces exactly one result: the
// counter state after the item is applied. A tick item counts down the main
// slot (stops at zero) and the slow-slot divider; when the divider is already
// zero it reloads from register 0, the phase bit toggles and the slow block
// runs (slow_slot_fired = 1). In normal mode the slow block counts down the
// on-time limit and steps the position, every other slow slot while
// decelerating; in learning mode it accumulates open/close times, and with
// learned deceleration in automatic programming a sub-divider (register 1)
// adds deceleration time. Load actions write counters, unknown actions only
// report the state. Throughput is one item per clock while results are taken;
// an item passes the input register, then the state update into the result
// register. The input is still taken while a result waits, as long as the
// input register is empty or drains in the same cycle. Configuration writes
// are taken in any cycle but should only happen while the block is idle.
module gate_travel_tick_counter #(
  parameter int COUNT_WIDTH = gttc_pkg::CountWidthDef
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // low to high: load_value[15:0], direction[17:16], learning_mode[18],
  // decelerating[19], learn_counting[20], learn_decel[21], auto_program[22],
  // zero pad[23]
  input  wire logic [gttc_pkg::InDataWidth-1:0]  in_tdata,
  // action[2:0]
  input  wire logic [gttc_pkg::InUserWidth-1:0]  in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // low to high: position[15:0], on_time_left[31:16], main_slot_left[47:32],
  // open_time[63:48], close_time[79:64], decel_open_time[95:80],
  // decel_close_time[111:96], slow_slot_fired[112], zero pad[119:113]
  output logic [gttc_pkg::OutDataWidth-1:0]      out_tdata,
  input  wire logic                              cfg_we,
  input  wire logic [gttc_pkg::CfgIdxWidth-1:0]  cfg_index,
  input  wire logic [gttc_pkg::RegWidth-1:0]     cfg_wdata
);
  import gttc_pkg::*;

  localparam int CW = COUNT_WIDTH;
  localparam logic [CW-1:0] CntZero = '0;

  // configuration
  logic [RegWidth-1:0] slow_reload_r, decel_reload_r;

  // input register
  logic                      s1_v_r;
  logic [2:0]                s1_action_r;
  logic [OutWidth-1:0]       s1_load_r;
  logic [1:0]                s1_dir_r;
  logic                      s1_learning_r, s1_decel_r, s1_lcount_r;
  logic                      s1_ldecel_r, s1_autoprog_r;

  // counter state
  logic [CW-1:0]       main_r, main_nxt;
  logic [RegWidth-1:0] slow_div_r, slow_div_nxt;
  logic [RegWidth-1:0] decel_div_r, decel_div_nxt;
  logic                phase_r, phase_nxt;
  logic [CW-1:0]       pos_r, pos_nxt;
  logic [CW-1:0]       ontime_r, ontime_nxt;
  logic [CW-1:0]       learn_r [NumLearn];
  logic [CW-1:0]       learn_nxt [NumLearn];
  logic                fired;

  // result register
  logic                    out_v_r;
  logic [OutDataWidth-1:0] out_data_r, out_data_nxt;

  logic advance, in_acc;
  logic [CW+OutWidth-1:0] load_ext;
  logic [CW-1:0]          load_cw;
  logic opening, closing;

  assign advance   = !out_v_r || out_tready;
  assign in_tready = !s1_v_r || advance;
  assign in_acc    = in_tvalid && in_tready;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  // load value masked to the counter width
  assign load_ext = {{CW{1'b0}}, s1_load_r};
  assign load_cw  = load_ext[CW-1:0];

  assign opening = (s1_dir_r == DIR_OPEN);
  assign closing = (s1_dir_r == DIR_CLOSE);

  // show low 16 bits of a counter, zero-extended when narrower
  function automatic logic [OutWidth-1:0] to_out(input logic [CW-1:0] v);
    logic [CW+OutWidth-1:0] e;
    e = {{OutWidth{1'b0}}, v};
    return e[OutWidth-1:0];
  endfunction

  always_comb begin
    main_nxt      = main_r;
    slow_div_nxt  = slow_div_r;
    decel_div_nxt = decel_div_r;
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    ontime_nxt    = ontime_r;
    for (int i = 0; i < NumLearn; i++) begin
      learn_nxt[i] = learn_r[i];
    end
    fired = 1'b0;

    unique case (s1_action_r)
      ACT_TICK: begin
        if (main_r != CntZero) main_nxt = main_r - 1'b1;
        if (slow_div_r != '0) begin
          slow_div_nxt = slow_div_r - 1'b1;
        end else begin
          slow_div_nxt = slow_reload_r;
          fired        = 1'b1;
          phase_nxt    = !phase_r;
          if (!s1_learning_r) begin
            if (ontime_r != CntZero && (opening || closing)) begin
              ontime_nxt = ontime_r - 1'b1;
            end
            // decelerating: step only when the toggled phase is 1
            if ((opening || closing) && (!s1_decel_r || phase_nxt)) begin
              if (opening) pos_nxt = pos_r + 1'b1;
              else         pos_nxt = pos_r - 1'b1;
            end
          end else begin
            if (s1_lcount_r && !s1_ldecel_r) begin
              if (opening)      learn_nxt[LT_OPEN]  = learn_r[LT_OPEN] + 1'b1;
              else if (closing) learn_nxt[LT_CLOSE] = learn_r[LT_CLOSE] + 1'b1;
            end
            if (s1_ldecel_r && s1_autoprog_r) begin
              if (decel_div_r != '0) begin
                decel_div_nxt = decel_div_r - 1'b1;
              end else begin
                decel_div_nxt = decel_reload_r;
                if (opening) begin
                  learn_nxt[LT_DECEL_OPEN] = learn_r[LT_DECEL_OPEN] + 1'b1;
                  learn_nxt[LT_OPEN]       = learn_r[LT_OPEN] + 1'b1;
                end else if (closing) begin
                  learn_nxt[LT_DECEL_CLOSE] = learn_r[LT_DECEL_CLOSE] + 1'b1;
                  learn_nxt[LT_CLOSE]       = learn_r[LT_CLOSE] + 1'b1;
                end
              end
            end
          end
        end
      end
      ACT_LOAD_POS:    pos_nxt = load_cw;
      ACT_LOAD_ONTIME: ontime_nxt = load_cw;
      ACT_LOAD_MAIN:   main_nxt = load_cw;
      ACT_CLEAR_LEARN: begin
        for (int i = 0; i < NumLearn; i++) begin
          learn_nxt[i] = CntZero;
        end
      end
      default: ; // unknown action: report state only
    endcase

    out_data_nxt = {7'b0, fired,
                    to_out(learn_nxt[LT_DECEL_CLOSE]),
                    to_out(learn_nxt[LT_DECEL_OPEN]),
                    to_out(learn_nxt[LT_CLOSE]),
                    to_out(learn_nxt[LT_OPEN]),
                    to_out(main_nxt), to_out(ontime_nxt), to_out(pos_nxt)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slow_reload_r  <= SlowReloadRst;
      decel_reload_r <= DecelReloadRst;
      s1_v_r         <= 1'b0;
      out_v_r        <= 1'b0;
      main_r         <= CntZero;
      slow_div_r     <= '0;
      decel_div_r    <= '0;
      phase_r        <= 1'b0;
      pos_r          <= CntZero;
      ontime_r       <= CntZero;
      for (int i = 0; i < NumLearn; i++) begin
        learn_r[i] <= CntZero;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SLOW_RELOAD:  slow_reload_r  <= cfg_wdata;
          REG_DECEL_RELOAD: decel_reload_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_acc)       s1_v_r <= 1'b1;
      else if (advance) s1_v_r <= 1'b0;
      if (advance) begin
        out_v_r <= s1_v_r;
        if (s1_v_r) begin
          main_r      <= main_nxt;
          slow_div_r  <= slow_div_nxt;
          decel_div_r <= decel_div_nxt;
          phase_r     <= phase_nxt;
          pos_r       <= pos_nxt;
          ontime_r    <= ontime_nxt;
          for (int i = 0; i < NumLearn; i++) begin
            learn_r[i] <= learn_nxt[i];
          end
        end
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_action_r   <= in_tuser;
      s1_load_r     <= in_tdata[15:0];
      s1_dir_r      <= in_tdata[17:16];
      s1_learning_r <= in_tdata[18];
      s1_decel_r    <= in_tdata[19];
      s1_lcount_r   <= in_tdata[20];
      s1_ldecel_r   <= in_tdata[21];
      s1_autoprog_r <= in_tdata[22];
    end
    if (advance && s1_v_r) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule
`default_nettype wire

@@ src/gttc_checker.sv @@
// Port-level checker for the gate travel tick counter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module gttc_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tvalid,
  input wire logic                             in_tready,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [gttc_pkg::OutDataWidth-1:0] out_tdata
);
  // result held until taken
  `ASSERT_RST(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid)
  `ASSERT_RST(a_out_stable, clk, rst_n, out_tvalid && !out_tready |=> $stable(out_tdata))
  // a ready sink never stalls the input side
  `ASSERT_RST(a_no_stall, clk, rst_n, out_tready |-> in_tready)
  // reset empties the result register
  `ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_tvalid)
  // right out of reset, an idle input keeps the output empty
  `ASSERT_RST(a_latency, clk, rst_n, $past(!rst_n) && !in_tvalid |=> !out_tvalid)
endmodule

bind gate_travel_tick_counter gttc_checker u_gttc_checker (.*);
`default_nettype wire
